### rtl/stwq_pkg.sv
`default_nettype none
package stwq_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int DATA_W          = 32;

  typedef logic [1:0] action_t;
  typedef logic [1:0] status_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam action_t ACT_PUSH    = 2'd0;
  localparam action_t ACT_POP     = 2'd1;
  localparam action_t ACT_ENQUEUE = 2'd2;
  localparam action_t ACT_DEQUEUE = 2'd3;

  localparam status_t ST_OK          = 2'd0;
  localparam status_t ST_STACK_EMPTY = 2'd1;
  localparam status_t ST_QUEUE_EMPTY = 2'd2;
  localparam status_t ST_FULL        = 2'd3;

  localparam logic SEL_QUEUE_A = 1'b0;
  localparam logic SEL_QUEUE_B = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic issue;   // latch command and launch the memory reads
    logic commit;  // read data back: update state and load the result
  } ctrl_cmd_t;

endpackage
`default_nettype wire

### rtl/stwq_if.sv
`default_nettype none
interface stwq_in_if;
  import stwq_pkg::*;
  logic    valid;
  logic    ready;
  action_t action;
  logic    queue_select;
  data_t   push_value;

  modport source (output valid, action, queue_select, push_value, input ready);
  modport sink   (input valid, action, queue_select, push_value, output ready);
endinterface

interface stwq_out_if;
  import stwq_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  logic    value_valid;
  data_t   out_value;

  modport source (output valid, status, value_valid, out_value, input ready);
  modport sink   (input valid, status, value_valid, out_value, output ready);
endinterface
`default_nettype wire

### rtl/stack_with_two_queues_unit.sv
// Flow: an accepted input beat passes through the execute state (registered memory read)
//   to the output state, which holds the result beat until taken; one item at a time,
//   set by the registered read of the stack and queue memories plus the output beat.
// Reset: synchronous, active low; clears the stack count, held value and queue pointers.
//   Memory contents are left as they are; no clearing pass is needed.
`default_nettype none
module stack_with_two_queues_unit #(
  parameter int STACK_DEPTH = stwq_pkg::STACK_DEPTH_DEF,
  parameter int QUEUE_DEPTH = stwq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  stwq_in_if.sink   in_chan,
  stwq_out_if.source out_chan
);
  import stwq_pkg::*;

  ctrl_cmd_t cmd;

  stwq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  stwq_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .action       (in_chan.action),
    .queue_select (in_chan.queue_select),
    .push_value   (in_chan.push_value),
    .status       (out_chan.status),
    .value_valid  (out_chan.value_valid),
    .out_value    (out_chan.out_value)
  );

endmodule
`default_nettype wire

### rtl/stwq_ram.sv
`default_nettype none
module stwq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/stwq_ctrl.sv
`default_nettype none
module stwq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output stwq_pkg::ctrl_cmd_t       cmd
);
  import stwq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready   = rst_n && (state_r == S_IDLE);
  assign out_valid  = rst_n && (state_r == S_OUT);
  assign cmd.issue  = in_valid && in_ready;
  assign cmd.commit = (state_r == S_EXEC);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.issue) state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_OUT;
      S_OUT: begin
        // hold the result beat until taken
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/stwq_dpath.sv
`default_nettype none
module stwq_dpath #(
  parameter int STACK_DEPTH = stwq_pkg::STACK_DEPTH_DEF,
  parameter int QUEUE_DEPTH = stwq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire stwq_pkg::ctrl_cmd_t  cmd,
  input  wire stwq_pkg::action_t    action,
  input  wire logic                 queue_select,
  input  wire stwq_pkg::data_t      push_value,
  output stwq_pkg::status_t         status,
  output logic                      value_valid,
  output stwq_pkg::data_t           out_value
);
  import stwq_pkg::*;

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int QSW = QAW + 1;

  logic [SCW-1:0] stk_cnt_r, stk_cnt_nxt;
  data_t          held_r, held_nxt;
  logic [QAW-1:0] qa_head_r, qa_head_nxt, qb_head_r, qb_head_nxt;
  logic [QCW-1:0] qa_cnt_r, qa_cnt_nxt, qb_cnt_r, qb_cnt_nxt;

  action_t act_r;
  logic    qsel_r;
  data_t   pv_r;

  status_t status_r, status_nxt;
  logic    vv_r, vv_nxt;
  data_t   val_r, val_nxt;

  logic [DATA_W-1:0] stk_rdata, qa_rdata, qb_rdata;
  logic              stk_we, qa_we, qb_we;
  logic [SAW-1:0]    stk_raddr;
  logic [SCW-1:0]    stk_cnt_dec;

  logic [QAW-1:0] sel_head, sel_head_inc, sel_tail;
  logic [QCW-1:0] sel_cnt;
  logic [QSW-1:0] tail_sum;
  logic [DATA_W-1:0] sel_rdata;

  assign stk_cnt_dec = stk_cnt_r - 1'b1;
  assign stk_raddr   = stk_cnt_dec[SAW-1:0];

  assign sel_head  = (qsel_r == SEL_QUEUE_B) ? qb_head_r : qa_head_r;
  assign sel_cnt   = (qsel_r == SEL_QUEUE_B) ? qb_cnt_r : qa_cnt_r;
  assign sel_rdata = (qsel_r == SEL_QUEUE_B) ? qb_rdata : qa_rdata;
  assign tail_sum  = QSW'(sel_head) + QSW'(sel_cnt);
  // wrap the tail once: the head stays below the depth and the count never exceeds it
  assign sel_tail  = (tail_sum >= QSW'(QUEUE_DEPTH)) ?
                     QAW'(tail_sum - QSW'(QUEUE_DEPTH)) : tail_sum[QAW-1:0];
  assign sel_head_inc = (sel_head == QAW'(QUEUE_DEPTH - 1)) ? '0 : sel_head + 1'b1;

  always_comb begin
    stk_cnt_nxt = stk_cnt_r;
    held_nxt    = held_r;
    qa_head_nxt = qa_head_r;
    qa_cnt_nxt  = qa_cnt_r;
    qb_head_nxt = qb_head_r;
    qb_cnt_nxt  = qb_cnt_r;
    status_nxt  = status_r;
    vv_nxt      = vv_r;
    val_nxt     = val_r;
    stk_we      = 1'b0;
    qa_we       = 1'b0;
    qb_we       = 1'b0;
    if (cmd.commit) begin
      status_nxt = ST_OK;
      vv_nxt     = 1'b0;
      val_nxt    = '0;
      case (act_r)
        ACT_PUSH: begin
          if (stk_cnt_r >= SCW'(STACK_DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            stk_we      = 1'b1;
            stk_cnt_nxt = stk_cnt_r + 1'b1;
          end
        end
        ACT_POP: begin
          if (stk_cnt_r == '0) begin
            status_nxt = ST_STACK_EMPTY;
          end else begin
            stk_cnt_nxt = stk_cnt_dec;
            held_nxt    = $signed(stk_rdata);
          end
        end
        ACT_ENQUEUE: begin
          if (sel_cnt >= QCW'(QUEUE_DEPTH)) begin
            status_nxt = ST_FULL;
          end else if (qsel_r == SEL_QUEUE_B) begin
            qb_we      = 1'b1;
            qb_cnt_nxt = qb_cnt_r + 1'b1;
          end else begin
            qa_we      = 1'b1;
            qa_cnt_nxt = qa_cnt_r + 1'b1;
          end
        end
        ACT_DEQUEUE: begin
          if (sel_cnt == '0) begin
            status_nxt = ST_QUEUE_EMPTY;
          end else begin
            vv_nxt  = 1'b1;
            val_nxt = $signed(sel_rdata);
            if (qsel_r == SEL_QUEUE_B) begin
              qb_head_nxt = sel_head_inc;
              qb_cnt_nxt  = qb_cnt_r - 1'b1;
            end else begin
              qa_head_nxt = sel_head_inc;
              qa_cnt_nxt  = qa_cnt_r - 1'b1;
            end
          end
        end
        default: status_nxt = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stk_cnt_r <= '0;
      held_r    <= '0;
      qa_head_r <= '0;
      qa_cnt_r  <= '0;
      qb_head_r <= '0;
      qb_cnt_r  <= '0;
    end else begin
      stk_cnt_r <= stk_cnt_nxt;
      held_r    <= held_nxt;
      qa_head_r <= qa_head_nxt;
      qa_cnt_r  <= qa_cnt_nxt;
      qb_head_r <= qb_head_nxt;
      qb_cnt_r  <= qb_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      act_r  <= action;
      qsel_r <= queue_select;
      pv_r   <= push_value;
    end
    status_r <= status_nxt;
    vv_r     <= vv_nxt;
    val_r    <= val_nxt;
  end

  assign status      = status_r;
  assign value_valid = vv_r;
  assign out_value   = val_r;

  // reads launch on the accepted beat; pointers are still those of that beat
  stwq_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_cnt_r[SAW-1:0]),
    .wdata ($unsigned(pv_r)),
    .re    (cmd.issue),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  stwq_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_qa_ram (
    .clk   (clk),
    .we    (qa_we),
    .waddr (sel_tail),
    .wdata ($unsigned(held_r)),
    .re    (cmd.issue),
    .raddr (qa_head_r),
    .rdata (qa_rdata)
  );

  stwq_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_qb_ram (
    .clk   (clk),
    .we    (qb_we),
    .waddr (sel_tail),
    .wdata ($unsigned(held_r)),
    .re    (cmd.issue),
    .raddr (qb_head_r),
    .rdata (qb_rdata)
  );

endmodule
`default_nettype wire

### rtl/stwq_checker.sv
`default_nettype none
module stwq_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire stwq_pkg::status_t status,
  input wire logic              value_valid,
  input wire stwq_pkg::data_t   out_value
);
  import stwq_pkg::*;

  // one item in flight: never open for input while a result beat is shown
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && !out_valid))
    else $error("no execute cycle after accept");

  a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && value_valid) |-> (status == ST_OK))
    else $error("value flagged on failed command");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !value_valid) |-> (out_value == '0))
    else $error("non-zero value without value flag");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(status) && $stable(value_valid) && $stable(out_value)))
    else $error("stalled result beat changed");

endmodule

bind stack_with_two_queues_unit stwq_checker u_stwq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .status      (out_chan.status),
  .value_valid (out_chan.value_valid),
  .out_value   (out_chan.out_value)
);
`default_nettype wire
